// File: sv/assert_macros.svh
// Assertion macros used by the root finder controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BRF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("brf assertion failed");

// Condition must never be true outside reset.
`define BRF_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("brf forbidden condition seen");

`endif

// File: sv/brf_pkg.sv
// Shared types, constants and saturating fixed-point helpers of the root finder.
package brf_pkg;

    localparam int FRACTION_BITS  = 40;
    localparam int MAX_ITERATIONS = 50;

    localparam logic [62:0] TOL_RESET = 63'd1099512;
    localparam logic signed [63:0] S_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] ONE_FIX = 64'sd1 <<< FRACTION_BITS;
    // 2 * round(3e-8 * 2^FRACTION_BITS)
    localparam logic [63:0] EPS2 =
        64'((((64'd3 << FRACTION_BITS) + 64'd50000000) / 64'd100000000) * 64'd2);

    // Result status codes
    localparam logic [2:0] STAT_EVAL  = 3'd0;
    localparam logic [2:0] STAT_ROOT  = 3'd1;
    localparam logic [2:0] STAT_NOBRK = 3'd2;
    localparam logic [2:0] STAT_LIMIT = 3'd3;
    localparam logic [2:0] STAT_FAIL  = 3'd4;

    typedef enum logic [4:0] {
        OP_ADD, OP_SUB, OP_HSUB, OP_NEG, OP_ABS, OP_MUL, OP_DIV,
        OP_LDS, OP_LDV, OP_EMIT,
        OP_ROTC, OP_SWAP, OP_DE, OP_FALL, OP_ADV
    } t_op;

    typedef enum logic [4:0] {
        SRC_A, SRC_B, SRC_C, SRC_FA, SRC_FB, SRC_FC, SRC_E,
        SRC_TOL1, SRC_XM, SRC_XM2, SRC_S, SRC_P, SRC_Q, SRC_R,
        SRC_T1, SRC_T2, SRC_ONE, SRC_EPS2, SRC_TOLH, SRC_ABSB
    } t_src;

    typedef enum logic [3:0] {
        DST_NONE, DST_T1, DST_T2, DST_TOL1, DST_XM, DST_XM2,
        DST_S, DST_P, DST_Q, DST_R, DST_D
    } t_dst;

    typedef struct packed {
        logic       go;
        t_op        op;
        t_src       sa;
        t_src       sb;
        t_dst       dst;
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic ss_ab;
        logic ss_bc;
        logic c_lt_b;
        logic conv;
        logic try_iq;
        logic a_eq_c;
        logic p_pos;
        logic accept_iq;
    } t_flags;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S_MIN : S_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S_MIN : S_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_neg(input logic signed [63:0] x);
        return (x == S_MIN) ? S_MAX : -x;
    endfunction

    function automatic logic signed [63:0] sat_abs(input logic signed [63:0] x);
        return x[63] ? sat_neg(x) : x;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    // Magnitude and sign to signed value, clamped to +-(2^63-1)
    function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
        logic signed [63:0] v;
        v = m[63] ? S_MAX : $signed(m);
        return neg ? -v : v;
    endfunction

    function automatic logic same_sign(input logic signed [63:0] x,
                                       input logic signed [63:0] y);
        return (!x[63] && (x != 0) && !y[63] && (y != 0)) || (x[63] && y[63]);
    endfunction

endpackage

// File: sv/brf_dp.sv
// Datapath of the root finder: search registers, saturating ALU, multiplier, divider.
module brf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [62:0]          i_cfg_wdata,
    input  logic signed [63:0]   i_lower_x,
    input  logic signed [63:0]   i_upper_x,
    input  logic signed [63:0]   i_f_lower,
    input  logic signed [63:0]   i_f_upper,
    input  logic signed [63:0]   i_f_trial,
    input  brf_pkg::t_cmd        i_cmd,
    output brf_pkg::t_flags      o_flags,
    output logic signed [63:0]   o_point_x
);
    import brf_pkg::*;

    // Search state and scratch registers
    logic signed [63:0] r_a, r_b, r_c, r_fa, r_fb, r_fc, r_d, r_e;
    logic signed [63:0] r_tol1, r_xm, r_xm2, r_s, r_p, r_q, r_r, r_t1, r_t2;
    logic [62:0]        r_tol;
    logic signed [63:0] r_point;

    // Execution unit
    logic               r_busy;
    t_op                r_op;
    t_dst               r_dst;
    logic signed [63:0] r_x, r_y;
    logic [6:0]         r_cnt;
    logic [127:0]       r_acc;
    logic [63:0]        r_pp;
    logic [1:0]         r_pps;
    logic [63:0]        r_rem, r_nlo, r_quo;

    logic signed [63:0] opa, opb, res, half_v, adv_t;
    logic [64:0]        half_s, div_sh, div_diff;
    logic [63:0]        mx, my, div_top, mul_m;
    logic [127:0]       pp_sh;
    logic               neg, fin, done, mul_hi_nz, div_ge;
    logic signed [63:0] p_dbl;

    function automatic logic signed [63:0] pick(input t_src s);
        logic signed [63:0] v;
        unique case (s)
            SRC_A:    v = r_a;
            SRC_B:    v = r_b;
            SRC_C:    v = r_c;
            SRC_FA:   v = r_fa;
            SRC_FB:   v = r_fb;
            SRC_FC:   v = r_fc;
            SRC_E:    v = r_e;
            SRC_TOL1: v = r_tol1;
            SRC_XM:   v = r_xm;
            SRC_XM2:  v = r_xm2;
            SRC_S:    v = r_s;
            SRC_P:    v = r_p;
            SRC_Q:    v = r_q;
            SRC_R:    v = r_r;
            SRC_T1:   v = r_t1;
            SRC_T2:   v = r_t2;
            SRC_ONE:  v = ONE_FIX;
            SRC_EPS2: v = $signed(EPS2);
            SRC_TOLH: v = $signed({2'b00, r_tol[62:1]});
            SRC_ABSB: v = sat_abs(r_b);
            default:  v = '0;
        endcase
        return v;
    endfunction

    // Operand selection
    assign opa = pick(i_cmd.sa);
    assign opb = pick(i_cmd.sb);

    // Shared arithmetic terms
    assign mx  = mag(r_x);
    assign my  = mag(r_y);
    assign neg = r_x[63] ^ r_y[63];

    assign mul_hi_nz = |r_acc[127:64+FRACTION_BITS];
    assign mul_m     = r_acc[FRACTION_BITS +: 64];

    assign div_top  = mx >> (64 - FRACTION_BITS);
    assign div_sh   = {r_rem, r_nlo[63]};
    assign div_ge   = div_sh >= {1'b0, my};
    assign div_diff = div_sh - {1'b0, my};

    // Halved difference, truncated toward zero
    always_comb begin
        half_v = sat_sub(r_x, r_y);
        half_s = {half_v[63], half_v} + {64'd0, half_v[63]};
    end

    // Partial product placement
    always_comb begin
        unique case (r_pps)
            2'd0:    pp_sh = {64'd0, r_pp};
            2'd1:    pp_sh = {32'd0, r_pp, 32'd0};
            default: pp_sh = {r_pp, 64'd0};
        endcase
    end

    // Step taken when the search point advances
    assign adv_t = (sat_abs(r_d) > r_tol1) ? r_d : (r_xm[63] ? -r_tol1 : r_tol1);

    // Result and completion of the running operation
    always_comb begin
        res = '0;
        fin = 1'b1;
        unique case (r_op)
            OP_ADD:  res = sat_add(r_x, r_y);
            OP_SUB:  res = sat_sub(r_x, r_y);
            OP_HSUB: res = half_s[64:1];
            OP_NEG:  res = sat_neg(r_x);
            OP_ABS:  res = sat_abs(r_x);
            OP_MUL: begin
                fin = (r_cnt == 7'd5);
                res = from_mag(mul_hi_nz ? '1 : mul_m, neg);
            end
            OP_DIV: begin
                fin = 1'b0;
                if (r_cnt == 7'd0) begin
                    if (mx == 64'd0) begin
                        fin = 1'b1;
                        res = '0;
                    end else if (my == 64'd0) begin
                        fin = 1'b1;
                        res = from_mag('1, r_x[63]);
                    end else if (div_top >= my) begin
                        fin = 1'b1;
                        res = from_mag('1, neg);
                    end
                end else if (r_cnt == 7'd65) begin
                    fin = 1'b1;
                    res = from_mag(r_quo, neg);
                end
            end
            default: res = '0;
        endcase
    end

    assign done = r_busy && fin;

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= OP_ADD;
            r_dst  <= DST_NONE;
            r_cnt  <= '0;
            r_tol  <= TOL_RESET;
            r_a    <= '0;
            r_b    <= '0;
            r_c    <= '0;
            r_fa   <= '0;
            r_fb   <= '0;
            r_fc   <= '0;
            r_d    <= '0;
            r_e    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (i_cmd.go) begin
                unique case (i_cmd.op)
                    OP_LDS: begin
                        r_a  <= i_lower_x;
                        r_b  <= i_upper_x;
                        r_c  <= i_upper_x;
                        r_fa <= i_f_lower;
                        r_fb <= i_f_upper;
                        r_fc <= i_f_upper;
                    end
                    OP_LDV: r_fb <= i_f_trial;
                    OP_EMIT: begin
                        r_point <= (i_cmd.status == STAT_EVAL || i_cmd.status == STAT_ROOT)
                                   ? r_b : '0;
                    end
                    default: begin
                        r_busy <= 1'b1;
                        r_op   <= i_cmd.op;
                        r_dst  <= i_cmd.dst;
                        r_x    <= opa;
                        r_y    <= opb;
                        r_cnt  <= '0;
                        r_acc  <= '0;
                    end
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                // Multiplier: four 32x32 partial products, each accumulated in the cycle after it is registered
                if (r_op == OP_MUL) begin
                    if (r_cnt < 7'd4) begin
                        r_pp  <= 64'((r_cnt[0] ? mx[63:32] : mx[31:0]) *
                                     (r_cnt[1] ? my[63:32] : my[31:0]));
                        r_pps <= 2'({1'b0, r_cnt[0]} + {1'b0, r_cnt[1]});
                    end
                    if (r_cnt != 7'd0 && r_cnt < 7'd5) begin
                        r_acc <= r_acc + pp_sh;
                    end
                end
                // Divider: restoring, one quotient bit a cycle
                if (r_op == OP_DIV) begin
                    if (r_cnt == 7'd0) begin
                        r_rem <= div_top;
                        r_nlo <= mx << FRACTION_BITS;
                        r_quo <= '0;
                    end else if (r_cnt <= 7'd64) begin
                        r_rem <= div_ge ? div_diff[63:0] : div_sh[63:0];
                        r_nlo <= r_nlo << 1;
                        r_quo <= {r_quo[62:0], div_ge};
                    end
                end
                if (done) begin
                    r_busy <= 1'b0;
                    unique case (r_op)
                        OP_ROTC: begin
                            r_c  <= r_a;
                            r_fc <= r_fa;
                            r_d  <= sat_sub(r_b, r_a);
                            r_e  <= sat_sub(r_b, r_a);
                        end
                        OP_SWAP: begin
                            r_a  <= r_b;
                            r_b  <= r_c;
                            r_c  <= r_b;
                            r_fa <= r_fb;
                            r_fb <= r_fc;
                            r_fc <= r_fb;
                        end
                        OP_DE: r_e <= r_d;
                        OP_FALL: begin
                            r_d <= r_xm;
                            r_e <= r_xm;
                        end
                        OP_ADV: begin
                            r_a  <= r_b;
                            r_fa <= r_fb;
                            r_b  <= sat_add(r_b, adv_t);
                        end
                        default: begin
                            unique case (r_dst)
                                DST_T1:   r_t1   <= res;
                                DST_T2:   r_t2   <= res;
                                DST_TOL1: r_tol1 <= res;
                                DST_XM:   r_xm   <= res;
                                DST_XM2:  r_xm2  <= res;
                                DST_S:    r_s    <= res;
                                DST_P:    r_p    <= res;
                                DST_Q:    r_q    <= res;
                                DST_R:    r_r    <= res;
                                DST_D:    r_d    <= res;
                                default:  r_t1   <= r_t1;
                            endcase
                        end
                    endcase
                end
            end
        end
    end

    // Status toward the controller
    assign p_dbl = sat_add(r_p, r_p);
    always_comb begin
        o_flags.busy      = r_busy;
        o_flags.done      = done;
        o_flags.ss_ab     = same_sign(r_fa, r_fb);
        o_flags.ss_bc     = same_sign(r_fb, r_fc);
        o_flags.c_lt_b    = sat_abs(r_fc) < sat_abs(r_fb);
        o_flags.conv      = (sat_abs(r_xm) <= r_tol1) || (r_fb == 0);
        o_flags.try_iq    = (sat_abs(r_e) >= r_tol1) && (sat_abs(r_fa) > sat_abs(r_fb));
        o_flags.a_eq_c    = (r_a == r_c);
        o_flags.p_pos     = r_p > 0;
        o_flags.accept_iq = (p_dbl < r_t1) && (p_dbl < r_r);
    end

    assign o_point_x = r_point;

endmodule

// File: sv/brf_ctrl.sv
// Controller of the root finder: handshakes, search sequencing, result register.
`include "assert_macros.svh"
module brf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic              i_eval_failed,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_status,
    input  brf_pkg::t_flags   i_flags,
    output brf_pkg::t_cmd     o_cmd
);
    import brf_pkg::*;

    localparam logic [5:0] S_IDLE = 6'd0,  S_CHK = 6'd1,   S_STEP0 = 6'd2,  S_STEP1 = 6'd3;
    localparam logic [5:0] S_MTOL = 6'd4,  S_ATOL = 6'd5,  S_HALF = 6'd6,   S_DEC = 6'd7;
    localparam logic [5:0] S_DIVS = 6'd8,  S_XM2 = 6'd9,   S_BR = 6'd10,    S_P2 = 6'd11;
    localparam logic [5:0] S_Q2 = 6'd12,   S_DIVQ = 6'd13, S_DIVR = 6'd14,  S_MA = 6'd15;
    localparam logic [5:0] S_SA = 6'd16,   S_MB = 6'd17,   S_SB = 6'd18,    S_SC = 6'd19;
    localparam logic [5:0] S_MC = 6'd20,   S_SD = 6'd21,   S_MD = 6'd22,    S_SE = 6'd23;
    localparam logic [5:0] S_SF = 6'd24,   S_ME = 6'd25,   S_SG = 6'd26,    S_MF = 6'd27;
    localparam logic [5:0] S_PSGN = 6'd28, S_PABS = 6'd29, S_M1A = 6'd30,   S_M1B = 6'd31;
    localparam logic [5:0] S_M1C = 6'd32,  S_M1D = 6'd33,  S_M1E = 6'd34,   S_M2A = 6'd35;
    localparam logic [5:0] S_M2B = 6'd36,  S_ACC = 6'd37,  S_DIVD = 6'd38,  S_ADV = 6'd39;
    localparam logic [5:0] S_EMIT = 6'd40, S_WAIT = 6'd41;

    logic [5:0] r_state, n_state, r_ret, n_ret;
    logic [2:0] r_status, n_status, r_ostatus;
    logic [5:0] r_iter, n_iter;
    logic       r_search, n_search, r_ovalid, n_ovalid;
    logic       issue, go_now, in_acc, out_free;
    t_op        op;
    t_src       sa, sb;
    t_dst       dst;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    // Next state and command issue
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_status = r_status;
        n_iter   = r_iter;
        n_search = r_search;
        n_ovalid = r_ovalid && i_stall;
        issue    = 1'b0;
        go_now   = 1'b0;
        op       = OP_ADD;
        sa       = SRC_ONE;
        sb       = SRC_ONE;
        dst      = DST_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_func) begin
                        go_now  = 1'b1;
                        op      = OP_LDS;
                        n_iter  = '0;
                        n_state = S_CHK;
                    end else if (!r_search || i_eval_failed) begin
                        n_search = 1'b0;
                        n_status = STAT_FAIL;
                        n_state  = S_EMIT;
                    end else begin
                        go_now = 1'b1;
                        op     = OP_LDV;
                        if (r_iter >= 6'(MAX_ITERATIONS)) begin
                            n_search = 1'b0;
                            n_status = STAT_LIMIT;
                            n_state  = S_EMIT;
                        end else begin
                            n_state = S_STEP0;
                        end
                    end
                end
            end
            S_CHK: begin
                if (i_flags.ss_ab) begin
                    n_search = 1'b0;
                    n_status = STAT_NOBRK;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_STEP0;
                end
            end
            S_STEP0: begin
                n_iter = r_iter + 6'd1;
                if (i_flags.ss_bc) begin
                    issue = 1'b1; op = OP_ROTC; n_ret = S_STEP1;
                end else begin
                    n_state = S_STEP1;
                end
            end
            S_STEP1: begin
                if (i_flags.c_lt_b) begin
                    issue = 1'b1; op = OP_SWAP; n_ret = S_MTOL;
                end else begin
                    n_state = S_MTOL;
                end
            end
            // Tolerance and bracket midpoint
            S_MTOL: begin
                issue = 1'b1; op = OP_MUL; sa = SRC_EPS2; sb = SRC_ABSB; dst = DST_T1;
                n_ret = S_ATOL;
            end
            S_ATOL: begin
                issue = 1'b1; op = OP_ADD; sa = SRC_T1; sb = SRC_TOLH; dst = DST_TOL1;
                n_ret = S_HALF;
            end
            S_HALF: begin
                issue = 1'b1; op = OP_HSUB; sa = SRC_C; sb = SRC_B; dst = DST_XM;
                n_ret = S_DEC;
            end
            S_DEC: begin
                if (i_flags.conv) begin
                    n_search = 1'b0;
                    n_status = STAT_ROOT;
                    n_state  = S_EMIT;
                end else if (i_flags.try_iq) begin
                    n_state = S_DIVS;
                end else begin
                    issue = 1'b1; op = OP_FALL; n_ret = S_ADV;
                end
            end
            // Interpolation
            S_DIVS: begin
                issue = 1'b1; op = OP_DIV; sa = SRC_FB; sb = SRC_FA; dst = DST_S;
                n_ret = S_XM2;
            end
            S_XM2: begin
                issue = 1'b1; op = OP_ADD; sa = SRC_XM; sb = SRC_XM; dst = DST_XM2;
                n_ret = S_BR;
            end
            S_BR: n_state = i_flags.a_eq_c ? S_P2 : S_DIVQ;
            S_P2: begin
                issue = 1'b1; op = OP_MUL; sa = SRC_XM2; sb = SRC_S; dst = DST_P;
                n_ret = S_Q2;
            end
            S_Q2: begin
                issue = 1'b1; op = OP_SUB; sa = SRC_ONE; sb = SRC_S; dst = DST_Q;
                n_ret = S_PSGN;
            end
            S_DIVQ: begin
                issue = 1'b1; op = OP_DIV; sa = SRC_FA; sb = SRC_FC; dst = DST_Q;
                n_ret = S_DIVR;
            end
            S_DIVR: begin
                issue = 1'b1; op = OP_DIV; sa = SRC_FB; sb = SRC_FC; dst = DST_R;
                n_ret = S_MA;
            end
            S_MA: begin
                issue = 1'b1; op = OP_MUL; sa = SRC_XM2; sb = SRC_Q; dst = DST_T1;
                n_ret = S_SA;
            end
            S_SA: begin
                issue = 1'b1; op = OP_SUB; sa = SRC_Q; sb = SRC_R; dst = DST_T2;
                n_ret = S_MB;
            end
            S_MB: begin
                issue = 1'b1; op = OP_MUL; sa = SRC_T1; sb = SRC_T2; dst = DST_T1;
                n_ret = S_SB;
            end
            S_SB: begin
                issue = 1'b1; op = OP_SUB; sa = SRC_B; sb = SRC_A; dst = DST_T2;
                n_ret = S_SC;
            end
            S_SC: begin
                issue = 1'b1; op = OP_SUB; sa = SRC_R; sb = SRC_ONE; dst = DST_P;
                n_ret = S_MC;
            end
            S_MC: begin
                issue = 1'b1; op = OP_MUL; sa = SRC_T2; sb = SRC_P; dst = DST_T2;
                n_ret = S_SD;
            end
            S_SD: begin
                issue = 1'b1; op = OP_SUB; sa = SRC_T1; sb = SRC_T2; dst = DST_T1;
                n_ret = S_MD;
            end
            S_MD: begin
                issue = 1'b1; op = OP_MUL; sa = SRC_S; sb = SRC_T1; dst = DST_P;
                n_ret = S_SE;
            end
            S_SE: begin
                issue = 1'b1; op = OP_SUB; sa = SRC_Q; sb = SRC_ONE; dst = DST_T1;
                n_ret = S_SF;
            end
            S_SF: begin
                issue = 1'b1; op = OP_SUB; sa = SRC_R; sb = SRC_ONE; dst = DST_T2;
                n_ret = S_ME;
            end
            S_ME: begin
                issue = 1'b1; op = OP_MUL; sa = SRC_T1; sb = SRC_T2; dst = DST_T1;
                n_ret = S_SG;
            end
            S_SG: begin
                issue = 1'b1; op = OP_SUB; sa = SRC_S; sb = SRC_ONE; dst = DST_T2;
                n_ret = S_MF;
            end
            S_MF: begin
                issue = 1'b1; op = OP_MUL; sa = SRC_T1; sb = SRC_T2; dst = DST_Q;
                n_ret = S_PSGN;
            end
            // Sign fixup and acceptance bounds
            S_PSGN: begin
                if (i_flags.p_pos) begin
                    issue = 1'b1; op = OP_NEG; sa = SRC_Q; dst = DST_Q; n_ret = S_PABS;
                end else begin
                    n_state = S_PABS;
                end
            end
            S_PABS: begin
                issue = 1'b1; op = OP_ABS; sa = SRC_P; dst = DST_P; n_ret = S_M1A;
            end
            S_M1A: begin
                issue = 1'b1; op = OP_ADD; sa = SRC_XM2; sb = SRC_XM; dst = DST_T2;
                n_ret = S_M1B;
            end
            S_M1B: begin
                issue = 1'b1; op = OP_MUL; sa = SRC_T2; sb = SRC_Q; dst = DST_T1;
                n_ret = S_M1C;
            end
            S_M1C: begin
                issue = 1'b1; op = OP_MUL; sa = SRC_TOL1; sb = SRC_Q; dst = DST_T2;
                n_ret = S_M1D;
            end
            S_M1D: begin
                issue = 1'b1; op = OP_ABS; sa = SRC_T2; dst = DST_T2; n_ret = S_M1E;
            end
            S_M1E: begin
                issue = 1'b1; op = OP_SUB; sa = SRC_T1; sb = SRC_T2; dst = DST_T1;
                n_ret = S_M2A;
            end
            S_M2A: begin
                issue = 1'b1; op = OP_MUL; sa = SRC_E; sb = SRC_Q; dst = DST_R;
                n_ret = S_M2B;
            end
            S_M2B: begin
                issue = 1'b1; op = OP_ABS; sa = SRC_R; dst = DST_R; n_ret = S_ACC;
            end
            S_ACC: begin
                if (i_flags.accept_iq) begin
                    issue = 1'b1; op = OP_DE; n_ret = S_DIVD;
                end else begin
                    issue = 1'b1; op = OP_FALL; n_ret = S_ADV;
                end
            end
            S_DIVD: begin
                issue = 1'b1; op = OP_DIV; sa = SRC_P; sb = SRC_Q; dst = DST_D;
                n_ret = S_ADV;
            end
            S_ADV: begin
                issue    = 1'b1;
                op       = OP_ADV;
                n_search = 1'b1;
                n_status = STAT_EVAL;
                n_ret    = S_EMIT;
            end
            // Result transaction into the output register
            S_EMIT: begin
                if (out_free) begin
                    go_now   = 1'b1;
                    op       = OP_EMIT;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_WAIT: begin
                if (i_flags.done) begin
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (issue) begin
            n_state = S_WAIT;
        end
    end

    assign o_cmd = '{go: issue || go_now, op: op, sa: sa, sb: sb, dst: dst,
                     status: r_status};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_status  <= STAT_EVAL;
            r_ostatus <= STAT_EVAL;
            r_iter    <= '0;
            r_search  <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_status <= n_status;
            r_iter   <= n_iter;
            r_search <= n_search;
            r_ovalid <= n_ovalid;
            if (r_state == S_EMIT && out_free) begin
                r_ostatus <= r_status;
            end
        end
    end

    assign o_valid  = r_ovalid;
    assign o_status = r_ostatus;

    // Checks
    `BRF_ASSERT(a_wait_busy, i_clk, i_rst_n, (r_state == S_WAIT) |-> i_flags.busy)
    `BRF_NEVER(a_go_busy, i_clk, i_rst_n, o_cmd.go && i_flags.busy)
    `BRF_ASSERT(a_iter_cap, i_clk, i_rst_n, r_iter <= 6'(MAX_ITERATIONS))
    `BRF_ASSERT(a_emit_sets, i_clk, i_rst_n, (r_state == S_EMIT && out_free) |=> r_ovalid)

endmodule

// File: sv/brent_root_finder.sv
// Brent root search engine, top level: a controller and a datapath.
// A start transaction (func 0) takes a bracket and its end values and returns one result: the
// first trial point, the root, or "not bracketed"; each value transaction (func 1) returns
// the next trial point, the root or an error. A Brent step takes longer with three-point
// interpolation than on the bisection path; its length is set by the shared bit-serial divider
// (up to four quotients per step) and the 32x32 multiplier, which forms each 64-bit product.
// One transaction is in flight at a time; a finished result waits in the output register
// while the next transaction is accepted. The tolerance is to be written by the user through
// i_cfg_we/i_cfg_wdata only while the block is idle; the block itself does not enforce this.
module brent_root_finder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [62:0]         i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_func,
    input  logic signed [63:0]  i_lower_x,
    input  logic signed [63:0]  i_upper_x,
    input  logic signed [63:0]  i_f_lower,
    input  logic signed [63:0]  i_f_upper,
    input  logic signed [63:0]  i_f_trial,
    input  logic                i_eval_failed,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic signed [63:0]  o_point_x
);
    import brf_pkg::*;

    t_flags flags;
    t_cmd   cmd;

    // Sequencer
    brf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_eval_failed (i_eval_failed),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .i_flags       (flags),
        .o_cmd         (cmd)
    );

    // Arithmetic and search registers
    brf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_lower_x   (i_lower_x),
        .i_upper_x   (i_upper_x),
        .i_f_lower   (i_f_lower),
        .i_f_upper   (i_f_upper),
        .i_f_trial   (i_f_trial),
        .i_cmd       (cmd),
        .o_flags     (flags),
        .o_point_x   (o_point_x)
    );

endmodule
